// ===== design/drpc_pkg.sv =====
// Shared types, constants and the helper function of the disc and ring pixel compositor.
`default_nettype none

package drpc_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int COORD_W  = 12;
    localparam int CENTER_W = 14;
    localparam int RADIUS_W = 12;
    localparam int PIXEL_W  = 32;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 3;

    // Offset to the centre: pixel column minus centre column, one bit wider than the centre.
    localparam int DELTA_W  = CENTER_W + 1;
    // Largest square of an offset is below 2^28.
    localparam int SQ_W     = 28;
    localparam int DIST_W   = SQ_W + 1;
    localparam int RSQ_W    = 2 * RADIUS_W;

    localparam logic [7:0]  FULL_ALPHA = 8'hff;
    localparam logic [15:0] ROUND_BIAS = 16'd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_OUTER_RADIUS = 3'd2,
        REG_INNER_RADIUS = 3'd3,
        REG_PAINT_COLOR  = 3'd4
    } cfg_reg_t;

    localparam logic [PIXEL_W-1:0] PAINT_COLOR_RESET = 32'hff00_0000;

    // Load enables of the two inner pipeline stages.
    typedef struct packed {
        logic s1;
        logic s2;
    } pipe_en_t;

    // Exact floor(x / 255) for any 16-bit x below 65280, by multiply-free reciprocal.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== design/disc_ring_pixel_compositor_unit.sv =====
// Top level of the disc and ring pixel compositor: configuration, pipeline control, output.
// Usage:
// Pixels arrive on the input channel (in_valid, in_stall) as a column, a row and the current
// frame colour. Each input transaction yields exactly one output transaction (out_valid,
// out_stall) carrying the colour to write back and a flag saying whether the pixel fell
// inside the disc or ring. Pixels outside the frame, or with a zero outer radius, pass
// through unchanged with the flag clear.
// Each pixel passes the stage 1, stage 2 and output registers; throughput is one pixel per
// clock while out_stall is low. The three-stage pipeline (offset, square, sum and compare)
// runs in parallel with the three-stage blend (products, rounded sums, divide by 255).
// Every stage has its own valid bit and loads whenever it is empty or its successor is
// loading, so bubbles are squeezed out while the receiver stalls and the block keeps
// taking transactions until all three stages hold a pixel. A stalled output holds its value.
// Configuration is written via cfg_we, cfg_index and cfg_data, by the user only while no
// pixel is in flight; the block does not enforce this. Radius squares are formed at write
// time. Indexes beyond the list are ignored. Reset empties the pipeline and restores centre
// (0, 0), both radii zero and an opaque black paint colour.
`default_nettype none

module disc_ring_pixel_compositor_unit
    import drpc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [COORD_W-1:0]   pixel_x,
    input  wire logic [COORD_W-1:0]   pixel_y,
    input  wire logic [PIXEL_W-1:0]   dest_pixel,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [PIXEL_W-1:0]        out_pixel,
    output logic                      covered
);

    logic signed [CENTER_W-1:0] center_x_reg, center_y_reg;
    logic [RADIUS_W-1:0]        outer_radius_reg, inner_radius_reg;
    logic [RSQ_W-1:0]           outer_sq_reg, inner_sq_reg;
    logic [PIXEL_W-1:0]         paint_color_reg;
    logic [RSQ_W-1:0]           radius_sq;

    logic       v1_reg, v2_reg, v3_reg;
    logic       ready1, ready2, ready3;
    pipe_en_t   pipe_en;

    logic                hit;
    logic [PIXEL_W-1:0]  blended, dest_s2;
    logic [PIXEL_W-1:0]  out_pixel_reg, out_pixel_next;
    logic                covered_reg;

    // Radius squares are taken from the write data so the compare path holds no multiplier.
    assign radius_sq = {{RADIUS_W{1'b0}}, cfg_data[RADIUS_W-1:0]}
                       * {{RADIUS_W{1'b0}}, cfg_data[RADIUS_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg     <= '0;
            center_y_reg     <= '0;
            outer_radius_reg <= '0;
            inner_radius_reg <= '0;
            outer_sq_reg     <= '0;
            inner_sq_reg     <= '0;
            paint_color_reg  <= PAINT_COLOR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CENTER_X:     center_x_reg <= cfg_data[CENTER_W-1:0];
                REG_CENTER_Y:     center_y_reg <= cfg_data[CENTER_W-1:0];
                REG_OUTER_RADIUS:
                begin
                    outer_radius_reg <= cfg_data[RADIUS_W-1:0];
                    outer_sq_reg     <= radius_sq;
                end
                REG_INNER_RADIUS:
                begin
                    inner_radius_reg <= cfg_data[RADIUS_W-1:0];
                    inner_sq_reg     <= radius_sq;
                end
                REG_PAINT_COLOR:  paint_color_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // A stage may load when it is empty or when its own content moves on.
    always_comb
    begin
        ready3     = !v3_reg || !out_stall;
        ready2     = !v2_reg || ready3;
        ready1     = !v1_reg || ready2;
        pipe_en.s1 = ready1;
        pipe_en.s2 = ready2;
    end

    assign in_stall = !ready1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    drpc_geom #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_geom (
        .clk          (clk),
        .pipe_en      (pipe_en),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .center_x     (center_x_reg),
        .center_y     (center_y_reg),
        .outer_radius (outer_radius_reg),
        .inner_radius (inner_radius_reg),
        .outer_sq     (outer_sq_reg),
        .inner_sq     (inner_sq_reg),
        .hit          (hit)
    );

    drpc_blend u_blend (
        .clk         (clk),
        .pipe_en     (pipe_en),
        .dest_pixel  (dest_pixel),
        .paint_color (paint_color_reg),
        .blended     (blended),
        .dest_s2     (dest_s2)
    );

    // Uncovered pixels return the frame colour untouched.
    assign out_pixel_next = hit ? blended : dest_s2;

    always_ff @(posedge clk)
    begin
        if (ready3)
        begin
            out_pixel_reg <= out_pixel_next;
            covered_reg   <= hit;
        end
    end

    assign out_valid = v3_reg;
    assign out_pixel = out_pixel_reg;
    assign covered   = covered_reg;

endmodule

`default_nettype wire

// ===== design/drpc_geom.sv =====
// Coverage pipeline: centre offsets, their squares and the disc and ring test.
`default_nettype none

module drpc_geom
    import drpc_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  wire logic                       clk,
    input  wire pipe_en_t                   pipe_en,
    input  wire logic [COORD_W-1:0]         pixel_x,
    input  wire logic [COORD_W-1:0]         pixel_y,
    input  wire logic signed [CENTER_W-1:0] center_x,
    input  wire logic signed [CENTER_W-1:0] center_y,
    input  wire logic [RADIUS_W-1:0]        outer_radius,
    input  wire logic [RADIUS_W-1:0]        inner_radius,
    input  wire logic [RSQ_W-1:0]           outer_sq,
    input  wire logic [RSQ_W-1:0]           inner_sq,
    output logic                            hit
);

    localparam logic [COORD_W+1:0] WIDTH_LIM  = (COORD_W + 2)'(MAX_WIDTH);
    localparam logic [COORD_W+1:0] HEIGHT_LIM = (COORD_W + 2)'(MAX_HEIGHT);

    logic signed [DELTA_W-1:0]   dx_reg, dx_next;
    logic signed [DELTA_W-1:0]   dy_reg, dy_next;
    logic                        elig1_reg, elig1_next;
    logic [SQ_W-1:0]             dx_sq_reg, dy_sq_reg;
    logic signed [2*DELTA_W-1:0] dx_prod, dy_prod;
    logic                        elig2_reg;
    logic [DIST_W-1:0]           dist_sq;
    logic                        in_outer, in_inner;

    // Stage 1: offsets and the frame and empty-disc checks.
    always_comb
    begin
        dx_next    = $signed({3'b000, pixel_x}) - DELTA_W'(center_x);
        dy_next    = $signed({3'b000, pixel_y}) - DELTA_W'(center_y);
        elig1_next = ({2'b00, pixel_x} < WIDTH_LIM) && ({2'b00, pixel_y} < HEIGHT_LIM)
                     && (outer_radius != '0);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en.s1)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            elig1_reg <= elig1_next;
        end
    end

    // Stage 2: one squarer per axis.
    assign dx_prod = (2*DELTA_W)'(dx_reg) * (2*DELTA_W)'(dx_reg);
    assign dy_prod = (2*DELTA_W)'(dy_reg) * (2*DELTA_W)'(dy_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en.s2)
        begin
            dx_sq_reg <= dx_prod[SQ_W-1:0];
            dy_sq_reg <= dy_prod[SQ_W-1:0];
            elig2_reg <= elig1_reg;
        end
    end

    // Final sum and the two radius compares feed the output register.
    always_comb
    begin
        dist_sq  = {1'b0, dx_sq_reg} + {1'b0, dy_sq_reg};
        in_outer = dist_sq <= DIST_W'(outer_sq);
        in_inner = (inner_radius != '0) && (dist_sq <= DIST_W'(inner_sq));
        hit      = elig2_reg && in_outer && !in_inner;
    end

endmodule

`default_nettype wire

// ===== design/drpc_blend.sv =====
// Blend pipeline: source-over mixing of the paint colour into the frame colour.
`default_nettype none

module drpc_blend
    import drpc_pkg::*;
(
    input  wire logic               clk,
    input  wire pipe_en_t           pipe_en,
    input  wire logic [PIXEL_W-1:0] dest_pixel,
    input  wire logic [PIXEL_W-1:0] paint_color,
    output logic [PIXEL_W-1:0]      blended,
    output logic [PIXEL_W-1:0]      dest_s2
);

    logic [7:0]  alpha, inv_alpha;
    logic [7:0]  src_ch [4];
    logic [15:0] src_prod_reg [4];
    logic [15:0] dst_prod_reg [4];
    logic [15:0] sum_reg [4];
    logic [PIXEL_W-1:0] dest1_reg, dest2_reg;

    assign alpha     = paint_color[31:24];
    assign inv_alpha = FULL_ALPHA - alpha;

    // The alpha channel mixes a full-scale source, which equals a plus the scaled destination.
    always_comb
    begin
        src_ch[0] = paint_color[7:0];
        src_ch[1] = paint_color[15:8];
        src_ch[2] = paint_color[23:16];
        src_ch[3] = FULL_ALPHA;
    end

    // Stage 1: eight 8 by 8 products.
    always_ff @(posedge clk)
    begin
        if (pipe_en.s1)
        begin
            for (int i = 0; i < 4; i++)
            begin
                src_prod_reg[i] <= {8'd0, src_ch[i]} * {8'd0, alpha};
                dst_prod_reg[i] <= {8'd0, dest_pixel[8*i +: 8]} * {8'd0, inv_alpha};
            end
            dest1_reg <= dest_pixel;
        end
    end

    // Stage 2: rounded sums, which never exceed 16 bits.
    always_ff @(posedge clk)
    begin
        if (pipe_en.s2)
        begin
            for (int i = 0; i < 4; i++)
            begin
                sum_reg[i] <= src_prod_reg[i] + dst_prod_reg[i] + ROUND_BIAS;
            end
            dest2_reg <= dest1_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            blended[8*i +: 8] = div255(sum_reg[i]);
        end
    end

    assign dest_s2 = dest2_reg;

endmodule

`default_nettype wire

// ===== design/drpc_checker.sv =====
// Port-level checker of the disc and ring pixel compositor and its bind statement.
`default_nettype none

module drpc_checker
    import drpc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [PIXEL_W-1:0] out_pixel,
    input wire logic               covered
);

    // A held result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_pixel) && $stable(covered))
        else $error("stalled output transaction changed");

    // With nothing waiting at the output every stage can load.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output is empty");

    // Accepted input passes stages 1, 2 and the output while out_stall is low.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall ##1 !out_stall ##1 !out_stall) |=> out_valid)
        else $error("output transaction missing after pipeline latency");

    // The pipeline is empty as reset is released.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight after reset");

endmodule

bind disc_ring_pixel_compositor_unit drpc_checker u_drpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .covered   (covered)
);

`default_nettype wire
